[rtl/icsd_pkg.sv]
// Shared constants, types and UTF-8 lead decode for the intraline span diff.
package icsd_pkg;

  localparam int MaxBytes = 64;
  localparam int LenW     = 7;
  localparam int KeyW     = 35;

  localparam logic [1:0] ModeLeft    = 2'd0;
  localparam logic [1:0] ModeRight   = 2'd1;
  localparam logic [1:0] ModeCompare = 2'd2;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] ContHi    = 8'hBF;
  localparam logic [7:0] AsciiHi   = 8'h7F;
  localparam logic [7:0] Lead2Lo   = 8'hC2;
  localparam logic [7:0] Lead2Hi   = 8'hDF;
  localparam logic [7:0] Lead3E0   = 8'hE0;
  localparam logic [7:0] Sec3E0Lo  = 8'hA0;
  localparam logic [7:0] Lead3Lo   = 8'hE1;
  localparam logic [7:0] Lead3Hi   = 8'hEC;
  localparam logic [7:0] Lead3ED   = 8'hED;
  localparam logic [7:0] Sec3EDHi  = 8'h9F;
  localparam logic [7:0] Lead3EE   = 8'hEE;
  localparam logic [7:0] Lead3EF   = 8'hEF;
  localparam logic [7:0] Lead4F0   = 8'hF0;
  localparam logic [7:0] Sec4F0Lo  = 8'h90;
  localparam logic [7:0] Lead4Lo   = 8'hF1;
  localparam logic [7:0] Lead4Hi   = 8'hF3;
  localparam logic [7:0] Lead4F4   = 8'hF4;
  localparam logic [7:0] Sec4F4Hi  = 8'h8F;

  typedef struct packed {
    logic [1:0] ncont;
    logic [7:0] sec_lo;
    logic [7:0] sec_hi;
  } lead_dec_t;

  function automatic lead_dec_t decode_lead(input logic [7:0] b);
    lead_dec_t d;
    d.ncont  = 2'd0;
    d.sec_lo = ContTag;
    d.sec_hi = ContHi;
    if (b >= Lead2Lo && b <= Lead2Hi) begin
      d.ncont = 2'd1;
    end else if (b == Lead3E0) begin
      d.ncont  = 2'd2;
      d.sec_lo = Sec3E0Lo;
    end else if ((b >= Lead3Lo && b <= Lead3Hi) || b == Lead3EE || b == Lead3EF) begin
      d.ncont = 2'd2;
    end else if (b == Lead3ED) begin
      d.ncont  = 2'd2;
      d.sec_hi = Sec3EDHi;
    end else if (b == Lead4F0) begin
      d.ncont  = 2'd3;
      d.sec_lo = Sec4F0Lo;
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      d.ncont = 2'd3;
    end else if (b == Lead4F4) begin
      d.ncont  = 2'd3;
      d.sec_hi = Sec4F4Hi;
    end
    return d;
  endfunction

endpackage

[rtl/intraline_changed_span_diff.sv]
// Top level of the intraline changed-span diff: buffers, splitter, LCS sequencer, span output.
//
//  channel  dir  fields
//  s_axis   in   tuser: mode[1:0]; tdata: data_byte[7:0]
//  m_axis   out  tuser: span_side, no_spans, truncated; tdata: span_start, span_end;
//                tlast: last_span
//
// A load item is stored on acceptance, up to MAX_BYTES per line. A compare item splits
// each line into code points, trims the common prefix and suffix, fills the LCS table
// (lm*rm cells), walks it and emits the changed spans, stalling on m_axis; the registered
// reads of the key, mark and table memories set the per-step cost.
// Reset clears lengths, overflow flag and control; buffers, keys, marks and table need
// no clearing. s_axis_tready is high only while no compare runs; a stalled m_axis holds
// the sequencer.
module intraline_changed_span_diff #(
  parameter int MAX_BYTES = icsd_pkg::MaxBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // span_start[6:0], span_end[13:7], zero[15:14]
  output logic [2:0]  m_axis_tuser,   // span_side[0], no_spans[1], truncated[2]
  output logic        m_axis_tlast
);

  localparam int AW    = $clog2(MAX_BYTES);
  localparam int Dim   = MAX_BYTES + 1;
  localparam int TW    = $clog2(Dim * Dim);
  localparam int LW    = icsd_pkg::LenW;
  localparam int KW    = icsd_pkg::KeyW;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_BYTES);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SP_CHK, ST_SP_LW, ST_SP_LD, ST_SP_CW, ST_SP_CT,
    ST_PRE_CHK, ST_PRE_W, ST_PRE_EV, ST_SUF_CHK, ST_SUF_W, ST_SUF_EV,
    ST_TB_W, ST_TB_EV, ST_WK_CHK, ST_WK_W, ST_WK_EV,
    ST_EM_W, ST_EM_EV, ST_EM_PUSH, ST_EM_FIN
  } state_e;

  state_e state_q;

  logic [7:0]    lb_mem [MAX_BYTES];
  logic [7:0]    rb_mem [MAX_BYTES];
  logic [KW-1:0] lk_mem [MAX_BYTES];
  logic [KW-1:0] rk_mem [MAX_BYTES];
  logic          lmk_mem [MAX_BYTES];
  logic          rmk_mem [MAX_BYTES];
  logic [LW-1:0] tbl_mem [Dim*Dim];

  logic [LW-1:0] ll_q, rl_q, lc_q, rc_q;
  logic          ovf_q;
  logic          sd_q;
  logic [LW-1:0] off_q, kc_q, bp_q;
  logic [1:0]    k_q;
  logic [7:0]    kb_q [4];
  icsd_pkg::lead_dec_t dec_q;
  logic [7:0]    bd_q;
  logic [KW-1:0] lkd_q, rkd_q;
  logic          lmd_q, rmd_q;
  logic [LW-1:0] tda_q, tdb_q;
  logic [LW-1:0] pre_q, ls_q, rs_q, i_q, j_q, lv_q;
  logic          es_q, in_run_q, em_done_q;
  logic [LW-1:0] idx_q, start_q, ns_start_q, ns_end_q;
  logic          ns_side_q;
  logic          pv_q, ps_side_q;
  logic [LW-1:0] ps_start_q, ps_end_q;
  logic          mv_q, m_side_q, m_none_q, m_trunc_q, m_last_q;
  logic [LW-1:0] m_start_q, m_end_q;

  logic          in_acc, out_free, mv_set, mclr;
  logic [LW-1:0] sp_len, lm, rm, em_cnt;
  logic [AW-1:0] la, ra;
  logic [TW-1:0] ta, tb, tw;
  logic          kwe, twe, key_eq;
  logic [KW-1:0] kwd;
  logic [LW-1:0] twd, tb_a, tb_b, tb_left, wk_a, wk_b;
  icsd_pkg::lead_dec_t dec;
  logic          ct_ok;
  logic [2:0]    klen;
  logic [7:0]    kb_n [4];

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !mv_q || m_axis_tready;
  assign mv_set   = (state_q == ST_EM_PUSH && pv_q && out_free) ||
                    (state_q == ST_EM_FIN && out_free);
  assign mclr     = key_eq && (state_q == ST_PRE_EV || state_q == ST_SUF_EV ||
                               state_q == ST_WK_EV);
  assign sp_len   = sd_q ? rl_q : ll_q;
  assign lm       = ls_q - pre_q;
  assign rm       = rs_q - pre_q;
  assign em_cnt   = es_q ? rc_q : lc_q;
  assign key_eq   = (lkd_q == rkd_q);
  assign dec      = icsd_pkg::decode_lead(bd_q);
  assign ct_ok    = (k_q == 2'd1) ? (bd_q >= dec_q.sec_lo && bd_q <= dec_q.sec_hi)
                                  : ((bd_q & icsd_pkg::ContMask) == icsd_pkg::ContTag);
  assign klen     = es_q ? rkd_q[KW-1:KW-3] : lkd_q[KW-1:KW-3];

  always_comb begin
    kb_n = kb_q;
    kb_n[k_q] = bd_q;
  end

  // key, mark and table read addresses follow the active phase
  always_comb begin
    la = idx_q[AW-1:0];
    ra = idx_q[AW-1:0];
    ta = TW'(TW'(i_q + 1'b1) * TW'(Dim) + TW'(j_q));
    tb = TW'(TW'(i_q) * TW'(Dim) + TW'(j_q) + TW'(1));
    case (state_q)
      ST_PRE_W, ST_PRE_EV: begin
        la = pre_q[AW-1:0];
        ra = pre_q[AW-1:0];
      end
      ST_SUF_W, ST_SUF_EV: begin
        la = AW'(ls_q - 1'b1);
        ra = AW'(rs_q - 1'b1);
      end
      ST_TB_W, ST_TB_EV: begin
        la = AW'(pre_q + i_q);
        ra = AW'(pre_q + j_q);
        ta = TW'(TW'(i_q + 1'b1) * TW'(Dim) + TW'(j_q) + TW'(1));
        tb = TW'(TW'(i_q + 1'b1) * TW'(Dim) + TW'(j_q));
      end
      ST_WK_W, ST_WK_EV: begin
        la = AW'(pre_q + i_q);
        ra = AW'(pre_q + j_q);
      end
      default: begin
      end
    endcase
  end

  // key and table writes
  always_comb begin
    kwe     = 1'b0;
    kwd     = {3'd1, kb_q[0], 24'd0};
    twe     = 1'b0;
    tw      = TW'(TW'(i_q) * TW'(Dim) + TW'(j_q));
    tb_a    = (i_q + 1'b1 == lm || j_q + 1'b1 == rm) ? '0 : tda_q;
    tb_b    = (i_q + 1'b1 == lm) ? '0 : tdb_q;
    tb_left = (j_q + 1'b1 == rm) ? '0 : lv_q;
    wk_a    = (i_q + 1'b1 == lm) ? '0 : tda_q;
    wk_b    = (j_q + 1'b1 == rm) ? '0 : tdb_q;
    twd     = key_eq ? LW'(tb_a + 1'b1) : ((tb_b >= tb_left) ? tb_b : tb_left);
    case (state_q)
      ST_SP_LD: begin
        if (dec.ncont == 2'd0 || bd_q <= icsd_pkg::AsciiHi ||
            off_q + LW'(dec.ncont) >= sp_len) begin
          kwe = 1'b1;
          kwd = {3'd1, bd_q, 24'd0};
        end
      end
      ST_SP_CT: begin
        if (!ct_ok) begin
          kwe = 1'b1;
        end else if (k_q == dec_q.ncont) begin
          kwe = 1'b1;
          kwd = {3'(dec_q.ncont) + 3'd1, kb_n[0], kb_n[1], kb_n[2], kb_n[3]};
        end
      end
      ST_TB_EV: twe = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == icsd_pkg::ModeLeft && ll_q < MaxLen) begin
      lb_mem[ll_q[AW-1:0]] <= s_axis_tdata;
    end
    if (in_acc && s_axis_tuser == icsd_pkg::ModeRight && rl_q < MaxLen) begin
      rb_mem[rl_q[AW-1:0]] <= s_axis_tdata;
    end
    bd_q <= sd_q ? rb_mem[bp_q[AW-1:0]] : lb_mem[bp_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (kwe && !sd_q) begin
      lk_mem[kc_q[AW-1:0]] <= kwd;
    end
    if (kwe && sd_q) begin
      rk_mem[kc_q[AW-1:0]] <= kwd;
    end
    lkd_q <= lk_mem[la];
    rkd_q <= rk_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if ((kwe && !sd_q) || mclr) begin
      lmk_mem[kwe ? kc_q[AW-1:0] : la] <= kwe;
    end
    if ((kwe && sd_q) || mclr) begin
      rmk_mem[kwe ? kc_q[AW-1:0] : ra] <= kwe;
    end
    lmd_q <= lmk_mem[la];
    rmd_q <= rmk_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (twe) begin
      tbl_mem[tw] <= twd;
    end
    tda_q <= tbl_mem[ta];
    tdb_q <= tbl_mem[tb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ll_q      <= '0;
      rl_q      <= '0;
      ovf_q     <= 1'b0;
      mv_q      <= 1'b0;
      pv_q      <= 1'b0;
      in_run_q  <= 1'b0;
      em_done_q <= 1'b0;
      sd_q      <= 1'b0;
      es_q      <= 1'b0;
    end else begin
      if (mv_set) begin
        mv_q <= 1'b1;
      end else if (m_axis_tready) begin
        mv_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (s_axis_tuser)
              icsd_pkg::ModeLeft: begin
                if (ll_q < MaxLen) ll_q <= ll_q + 1'b1;
                else ovf_q <= 1'b1;
              end
              icsd_pkg::ModeRight: begin
                if (rl_q < MaxLen) rl_q <= rl_q + 1'b1;
                else ovf_q <= 1'b1;
              end
              icsd_pkg::ModeCompare: begin
                sd_q    <= 1'b0;
                off_q   <= '0;
                kc_q    <= '0;
                state_q <= ST_SP_CHK;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SP_CHK: begin
          if (off_q < sp_len) begin
            bp_q    <= off_q;
            state_q <= ST_SP_LW;
          end else begin
            if (!sd_q) begin
              lc_q  <= kc_q;
              sd_q  <= 1'b1;
              off_q <= '0;
              kc_q  <= '0;
            end else begin
              rc_q    <= kc_q;
              pre_q   <= '0;
              state_q <= ST_PRE_CHK;
            end
          end
        end
        ST_SP_LW: state_q <= ST_SP_LD;
        ST_SP_LD: begin
          if (kwe) begin
            off_q   <= off_q + 1'b1;
            kc_q    <= kc_q + 1'b1;
            state_q <= ST_SP_CHK;
          end else begin
            dec_q   <= dec;
            kb_q[0] <= bd_q;
            kb_q[1] <= '0;
            kb_q[2] <= '0;
            kb_q[3] <= '0;
            k_q     <= 2'd1;
            bp_q    <= off_q + 1'b1;
            state_q <= ST_SP_CW;
          end
        end
        ST_SP_CW: state_q <= ST_SP_CT;
        ST_SP_CT: begin
          if (kwe) begin
            off_q   <= ct_ok ? off_q + LW'(dec_q.ncont) + 1'b1 : off_q + 1'b1;
            kc_q    <= kc_q + 1'b1;
            state_q <= ST_SP_CHK;
          end else begin
            kb_q[k_q] <= bd_q;
            k_q       <= k_q + 1'b1;
            bp_q      <= bp_q + 1'b1;
            state_q   <= ST_SP_CW;
          end
        end
        ST_PRE_CHK: begin
          if (pre_q < lc_q && pre_q < rc_q) begin
            state_q <= ST_PRE_W;
          end else begin
            ls_q    <= lc_q;
            rs_q    <= rc_q;
            state_q <= ST_SUF_CHK;
          end
        end
        ST_PRE_W: state_q <= ST_PRE_EV;
        ST_PRE_EV: begin
          if (key_eq) begin
            pre_q   <= pre_q + 1'b1;
            state_q <= ST_PRE_CHK;
          end else begin
            ls_q    <= lc_q;
            rs_q    <= rc_q;
            state_q <= ST_SUF_CHK;
          end
        end
        ST_SUF_CHK: begin
          if (ls_q > pre_q && rs_q > pre_q) begin
            state_q <= ST_SUF_W;
          end else if (lm != '0 && rm != '0) begin
            i_q     <= lm - 1'b1;
            j_q     <= rm - 1'b1;
            state_q <= ST_TB_W;
          end else begin
            es_q     <= 1'b0;
            idx_q    <= '0;
            off_q    <= '0;
            in_run_q <= 1'b0;
            pv_q     <= 1'b0;
            state_q  <= ST_EM_W;
          end
        end
        ST_SUF_W: state_q <= ST_SUF_EV;
        ST_SUF_EV: begin
          if (key_eq) begin
            ls_q      <= ls_q - 1'b1;
            rs_q      <= rs_q - 1'b1;
            state_q   <= ST_SUF_CHK;
          end else if (lm != '0 && rm != '0) begin
            i_q     <= lm - 1'b1;
            j_q     <= rm - 1'b1;
            state_q <= ST_TB_W;
          end else begin
            es_q     <= 1'b0;
            idx_q    <= '0;
            off_q    <= '0;
            in_run_q <= 1'b0;
            pv_q     <= 1'b0;
            state_q  <= ST_EM_W;
          end
        end
        ST_TB_W: state_q <= ST_TB_EV;
        ST_TB_EV: begin
          lv_q <= twd;
          if (j_q != '0) begin
            j_q     <= j_q - 1'b1;
            state_q <= ST_TB_W;
          end else if (i_q != '0) begin
            i_q     <= i_q - 1'b1;
            j_q     <= rm - 1'b1;
            state_q <= ST_TB_W;
          end else begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= ST_WK_CHK;
          end
        end
        ST_WK_CHK: begin
          if (i_q < lm && j_q < rm) begin
            state_q <= ST_WK_W;
          end else begin
            es_q     <= 1'b0;
            idx_q    <= '0;
            off_q    <= '0;
            in_run_q <= 1'b0;
            pv_q     <= 1'b0;
            state_q  <= ST_EM_W;
          end
        end
        ST_WK_W: state_q <= ST_WK_EV;
        ST_WK_EV: begin
          state_q <= ST_WK_CHK;
          if (key_eq) begin
            i_q       <= i_q + 1'b1;
            j_q       <= j_q + 1'b1;
          end else if (wk_a >= wk_b) begin
            i_q <= i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_EM_W: state_q <= ST_EM_EV;
        ST_EM_EV: begin
          if (idx_q == em_cnt) begin
            if (in_run_q) begin
              ns_side_q  <= es_q;
              ns_start_q <= start_q;
              ns_end_q   <= off_q;
              in_run_q   <= 1'b0;
              em_done_q  <= 1'b1;
              state_q    <= ST_EM_PUSH;
            end else if (!es_q) begin
              es_q    <= 1'b1;
              idx_q   <= '0;
              off_q   <= '0;
              state_q <= ST_EM_W;
            end else begin
              state_q <= ST_EM_FIN;
            end
          end else begin
            off_q   <= off_q + LW'(klen);
            idx_q   <= idx_q + 1'b1;
            if (es_q ? rmd_q : lmd_q) begin
              state_q <= ST_EM_W;
              if (!in_run_q) begin
                start_q  <= off_q;
                in_run_q <= 1'b1;
              end
            end else if (in_run_q) begin
              ns_side_q  <= es_q;
              ns_start_q <= start_q;
              ns_end_q   <= off_q;
              in_run_q   <= 1'b0;
              em_done_q  <= 1'b0;
              state_q    <= ST_EM_PUSH;
            end else begin
              state_q <= ST_EM_W;
            end
          end
        end
        ST_EM_PUSH: begin
          if (!pv_q || out_free) begin
            if (pv_q) begin
              m_side_q  <= ps_side_q;
              m_start_q <= ps_start_q;
              m_end_q   <= ps_end_q;
              m_none_q  <= 1'b0;
              m_trunc_q <= ovf_q;
              m_last_q  <= 1'b0;
            end
            pv_q       <= 1'b1;
            ps_side_q  <= ns_side_q;
            ps_start_q <= ns_start_q;
            ps_end_q   <= ns_end_q;
            if (!em_done_q) begin
              state_q <= ST_EM_W;
            end else if (!es_q) begin
              es_q    <= 1'b1;
              idx_q   <= '0;
              off_q   <= '0;
              state_q <= ST_EM_W;
            end else begin
              state_q <= ST_EM_FIN;
            end
          end
        end
        ST_EM_FIN: begin
          if (out_free) begin
            m_side_q  <= pv_q ? ps_side_q : 1'b0;
            m_start_q <= pv_q ? ps_start_q : '0;
            m_end_q   <= pv_q ? ps_end_q : '0;
            m_none_q  <= !pv_q;
            m_trunc_q <= ovf_q;
            m_last_q  <= 1'b1;
            pv_q      <= 1'b0;
            ll_q      <= '0;
            rl_q      <= '0;
            ovf_q     <= 1'b0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {2'b00, m_end_q, m_start_q};
  assign m_axis_tuser  = {m_trunc_q, m_none_q, m_side_q};
  assign m_axis_tlast  = m_last_q;

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("no-change item must be the last and carry a zero span");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[6:0] < m_axis_tdata[13:7])
    else $error("span start must lie before span end");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ll_q <= MaxLen && rl_q <= MaxLen)
    else $error("line length beyond capacity");

endmodule
